/* sv/ierf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ierf_pkg: shared definitions for the ICMP echo reply filter
// Holds the sequencer states, status codes, register indexes and the
// protocol constants used by the filter and its statistics engine.
// ----------------------------------------------------------------------------
package ierf_pkg;

	// Default packet length limit in bytes.
	localparam int MaxPacketBytes = 2048;

	// Configuration port.
	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 16;
	localparam logic [CfgIndexW-1:0] CfgEchoIdentifier = 2'd0;
	localparam logic [CfgIndexW-1:0] CfgStartSequence  = 2'd1;

	// Protocol constants.
	localparam int IpMinBytes     = 20;
	localparam int IcmpHdrBytes   = 8;
	localparam logic [3:0] MinHeaderWords = 4'd5;
	localparam logic [7:0] ProtoIcmp      = 8'd1;
	localparam logic [7:0] TypeEchoReply  = 8'd0;

	// Serial arithmetic lengths: one multiplier bit per cycle, then one
	// quotient bit per cycle over the 57-bit numerator.
	localparam int TimeW    = 24;
	localparam int CountW   = 32;
	localparam int MulSteps = TimeW;
	localparam int NumW     = TimeW + CountW + 1;
	localparam int DivSteps = NumW;
	localparam int StepCntW = $clog2(DivSteps);

	// Result status codes.
	typedef enum logic [2:0] {
		ST_ACCEPTED     = 3'd0,
		ST_TRUNCATED    = 3'd1,
		ST_HEADER_SHORT = 3'd2,
		ST_NOT_ICMP     = 3'd3,
		ST_NOT_REPLY    = 3'd4,
		ST_BAD_CODE     = 3'd5,
		ST_BAD_IDENT    = 3'd6,
		ST_BAD_SEQUENCE = 3'd7
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_PREP,
		S_DIV
	} state_t;

endpackage

/* sv/icmp_echo_reply_filter_rtt_stats_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_echo_reply_filter_rtt_stats_top: ICMP echo reply filter with RTT stats
// Checks a received IPv4 packet byte by byte, reports one status per packet
// and keeps minimum, maximum, running average and square sum of the RTT.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  -------  --------------------  ----------------------------------------
//  in       in_valid / in_ready   data_byte, last_byte, rtt_time
//  out      out_valid / out_ready status, icmp_length, ttl, reply_sequence,
//                                 source_address, reply_time, rtt_* stats,
//                                 received_count
//  cfg      cfg_we                cfg_index, cfg_data
//
// A packet byte that is not the last is taken whenever the block is idle. The
// last byte leads to a check state; a rejected packet then has its result
// ready. An accepted packet instead goes through a bit-serial multiply, a sum
// step and a restoring division for the average. No bytes are taken while the
// statistics engine runs, and a last byte waits until the previous result has
// been taken. Reset clears all statistics.
//
module icmp_echo_reply_filter_rtt_stats_top #(
	parameter int MAX_PACKET_BYTES = ierf_pkg::MaxPacketBytes
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_we,
	input  logic [ierf_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [ierf_pkg::CfgDataW-1:0]  cfg_data,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	input  logic [23:0]                    rtt_time,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     status,
	output logic [11:0]                    icmp_length,
	output logic [7:0]                     ttl,
	output logic [15:0]                    reply_sequence,
	output logic [31:0]                    source_address,
	output logic [23:0]                    reply_time,
	output logic [23:0]                    rtt_minimum,
	output logic [23:0]                    rtt_maximum,
	output logic [23:0]                    rtt_average,
	output logic [63:0]                    rtt_square_sum,
	output logic [31:0]                    received_count
);

	localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CmpW = (PosW > 7) ? PosW : 7;
	localparam int LenW = (PosW > 12) ? PosW : 12;
	localparam int TW   = ierf_pkg::TimeW;
	localparam int CW   = ierf_pkg::CountW;
	localparam int NW   = ierf_pkg::NumW;
	localparam int SW   = ierf_pkg::StepCntW;
	localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PACKET_BYTES);

	ierf_pkg::state_t state_q, state_d;

	// Packet capture registers.
	logic [PosW-1:0] pos_q;
	logic [3:0]      hw_q;
	logic [7:0]      ttl_q, proto_q, type_q, code_q;
	logic [31:0]     src_q;
	logic [15:0]     ident_q, seqs_q;
	logic [TW-1:0]   rtt_q;

	// Configuration and running statistics.
	logic [15:0]     ident_cfg_q, expseq_q;
	logic [CW-1:0]   count_q;
	logic [TW-1:0]   min_q, max_q, avg_q;
	logic [63:0]     sqsum_q;

	// Serial arithmetic.
	logic [SW-1:0]   cnt_q;
	logic [2*TW-1:0] sq_acc_q, sq_mcand_q;
	logic [TW-1:0]   sq_mplier_q;
	logic [NW-2:0]   pr_acc_q, pr_mcand_q;
	logic [TW-1:0]   pr_mplier_q;
	logic [NW-1:0]   num_q;
	logic [CW-1:0]   rem_q;
	logic [TW-1:0]   quo_q;

	// Output register.
	logic            out_valid_q;
	logic [2:0]      status_q;
	logic [11:0]     icmp_len_q;
	logic [7:0]      ttl_out_q;
	logic [15:0]     seq_out_q;
	logic [31:0]     src_out_q;
	logic [TW-1:0]   rtime_out_q;

	logic            in_fire;
	logic [CmpW-1:0] pos_x, h_x;
	ierf_pkg::status_t chk_status;
	logic [LenW-1:0] len_diff;
	logic [CW-1:0]   count_next;
	logic [CW:0]     rem_sh, rem_sub;
	logic            q_bit;
	logic [64:0]     sq_total;

	assign in_fire = in_valid && in_ready;
	assign pos_x   = CmpW'(pos_q);
	assign h_x     = CmpW'({hw_q, 2'b00});

	// Status of the finished packet, checks in priority order.
	always_comb begin
		if (pos_x < CmpW'(ierf_pkg::IpMinBytes)) begin
			chk_status = ierf_pkg::ST_TRUNCATED;
		end else if (hw_q < ierf_pkg::MinHeaderWords) begin
			chk_status = ierf_pkg::ST_HEADER_SHORT;
		end else if (pos_x < h_x) begin
			chk_status = ierf_pkg::ST_TRUNCATED;
		end else if (proto_q != ierf_pkg::ProtoIcmp) begin
			chk_status = ierf_pkg::ST_NOT_ICMP;
		end else if (pos_x < h_x + CmpW'(ierf_pkg::IcmpHdrBytes)) begin
			chk_status = ierf_pkg::ST_TRUNCATED;
		end else if (type_q != ierf_pkg::TypeEchoReply) begin
			chk_status = ierf_pkg::ST_NOT_REPLY;
		end else if (code_q != 8'd0) begin
			chk_status = ierf_pkg::ST_BAD_CODE;
		end else if (ident_q != ident_cfg_q) begin
			chk_status = ierf_pkg::ST_BAD_IDENT;
		end else if (seqs_q != expseq_q) begin
			chk_status = ierf_pkg::ST_BAD_SEQUENCE;
		end else begin
			chk_status = ierf_pkg::ST_ACCEPTED;
		end
	end

	assign len_diff   = LenW'(pos_q) - LenW'({hw_q, 2'b00});
	assign count_next = (count_q != '1) ? count_q + CW'(1) : count_q;

	// One restoring division step and the saturating square sum.
	assign rem_sh   = {rem_q, num_q[NW-1]};
	assign rem_sub  = rem_sh - {1'b0, count_q};
	assign q_bit    = (rem_sh >= {1'b0, count_q});
	assign sq_total = {1'b0, sqsum_q} + 65'(sq_acc_q);

	// Next state and input ready.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ierf_pkg::S_IDLE: begin
				in_ready = !last_byte || !out_valid_q;
				if (in_fire && last_byte) begin
					state_d = ierf_pkg::S_CHECK;
				end
			end
			ierf_pkg::S_CHECK: begin
				if (chk_status == ierf_pkg::ST_ACCEPTED) begin
					state_d = ierf_pkg::S_MUL;
				end else begin
					state_d = ierf_pkg::S_IDLE;
				end
			end
			ierf_pkg::S_MUL: begin
				if (cnt_q == SW'(ierf_pkg::MulSteps - 1)) begin
					state_d = ierf_pkg::S_PREP;
				end
			end
			ierf_pkg::S_PREP: begin
				state_d = ierf_pkg::S_DIV;
			end
			ierf_pkg::S_DIV: begin
				if (cnt_q == SW'(ierf_pkg::DivSteps - 1)) begin
					state_d = ierf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ierf_pkg::S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ierf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture, configuration and statistics registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hw_q        <= '0;
			ttl_q       <= '0;
			proto_q     <= '0;
			src_q       <= '0;
			type_q      <= '0;
			code_q      <= '0;
			ident_q     <= '0;
			seqs_q      <= '0;
			ident_cfg_q <= '0;
			expseq_q    <= '0;
			count_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			avg_q       <= '0;
			sqsum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result is taken downstream.
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// Configuration writes; indexes beyond the list are ignored.
			if (cfg_we) begin
				case (cfg_index)
					ierf_pkg::CfgEchoIdentifier: ident_cfg_q <= cfg_data;
					ierf_pkg::CfgStartSequence:  expseq_q    <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				ierf_pkg::S_IDLE: begin
					// Byte capture; bytes past the length limit are dropped.
					if (in_fire && pos_q < MaxPos) begin
						pos_q <= pos_q + PosW'(1);
						if (pos_x == CmpW'(0))  hw_q    <= data_byte[3:0];
						if (pos_x == CmpW'(8))  ttl_q   <= data_byte;
						if (pos_x == CmpW'(9))  proto_q <= data_byte;
						if (pos_x == CmpW'(12)) src_q[31:24] <= data_byte;
						if (pos_x == CmpW'(13)) src_q[23:16] <= data_byte;
						if (pos_x == CmpW'(14)) src_q[15:8]  <= data_byte;
						if (pos_x == CmpW'(15)) src_q[7:0]   <= data_byte;
						// ICMP fields sit behind the IP header; the first
						// byte never counts as one of them.
						if (pos_x != CmpW'(0)) begin
							if (pos_x == h_x)             type_q        <= data_byte;
							if (pos_x == h_x + CmpW'(1))  code_q        <= data_byte;
							if (pos_x == h_x + CmpW'(4))  ident_q[15:8] <= data_byte;
							if (pos_x == h_x + CmpW'(5))  ident_q[7:0]  <= data_byte;
							if (pos_x == h_x + CmpW'(6))  seqs_q[15:8]  <= data_byte;
							if (pos_x == h_x + CmpW'(7))  seqs_q[7:0]   <= data_byte;
						end
					end
				end
				ierf_pkg::S_CHECK: begin
					// Start the next packet clean.
					pos_q   <= '0;
					hw_q    <= '0;
					ttl_q   <= '0;
					proto_q <= '0;
					src_q   <= '0;
					type_q  <= '0;
					code_q  <= '0;
					ident_q <= '0;
					seqs_q  <= '0;
					if (chk_status == ierf_pkg::ST_ACCEPTED) begin
						expseq_q <= expseq_q + 16'd1;
						count_q  <= count_next;
						if (rtt_q > max_q) max_q <= rtt_q;
						if (min_q == '0 || rtt_q < min_q) min_q <= rtt_q;
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				ierf_pkg::S_PREP: begin
					sqsum_q <= sq_total[64] ? '1 : sq_total[63:0];
				end
				ierf_pkg::S_DIV: begin
					if (cnt_q == SW'(ierf_pkg::DivSteps - 1)) begin
						avg_q       <= {quo_q[TW-2:0], q_bit};
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Serial multiply and divide datapath, and the result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ierf_pkg::S_IDLE: begin
				if (in_fire && last_byte) begin
					rtt_q <= rtt_time;
				end
			end
			ierf_pkg::S_CHECK: begin
				status_q    <= chk_status;
				ttl_out_q   <= ttl_q;
				seq_out_q   <= seqs_q;
				src_out_q   <= src_q;
				if (chk_status == ierf_pkg::ST_ACCEPTED) begin
					icmp_len_q  <= len_diff[11:0];
					rtime_out_q <= rtt_q;
				end else begin
					icmp_len_q  <= '0;
					rtime_out_q <= '0;
				end
				// Load both multipliers: t * t and average * (n - 1).
				cnt_q       <= '0;
				sq_acc_q    <= '0;
				sq_mcand_q  <= (2*TW)'(rtt_q);
				sq_mplier_q <= rtt_q;
				pr_acc_q    <= '0;
				pr_mcand_q  <= (NW-1)'(count_next - CW'(1));
				pr_mplier_q <= avg_q;
			end
			ierf_pkg::S_MUL: begin
				cnt_q <= cnt_q + SW'(1);
				if (sq_mplier_q[0]) sq_acc_q <= sq_acc_q + sq_mcand_q;
				if (pr_mplier_q[0]) pr_acc_q <= pr_acc_q + pr_mcand_q;
				sq_mcand_q  <= {sq_mcand_q[2*TW-2:0], 1'b0};
				pr_mcand_q  <= {pr_mcand_q[NW-3:0], 1'b0};
				sq_mplier_q <= {1'b0, sq_mplier_q[TW-1:1]};
				pr_mplier_q <= {1'b0, pr_mplier_q[TW-1:1]};
			end
			ierf_pkg::S_PREP: begin
				num_q <= {1'b0, pr_acc_q} + NW'(rtt_q);
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			ierf_pkg::S_DIV: begin
				cnt_q <= cnt_q + SW'(1);
				num_q <= {num_q[NW-2:0], 1'b0};
				quo_q <= {quo_q[TW-2:0], q_bit};
				rem_q <= q_bit ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign icmp_length    = icmp_len_q;
	assign ttl            = ttl_out_q;
	assign reply_sequence = seq_out_q;
	assign source_address = src_out_q;
	assign reply_time     = rtime_out_q;
	assign rtt_minimum    = min_q;
	assign rtt_maximum    = max_q;
	assign rtt_average    = avg_q;
	assign rtt_square_sum = sqsum_q;
	assign received_count = count_q;

`ifndef ASSERT_OFF
	// A last byte is only taken when the result slot is free.
	a_last_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_byte |-> !out_valid_q)
		else $error("last byte taken while a result was pending");

	// A result appears only after the check or the final division step.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |->
			$past(state_q) == ierf_pkg::S_CHECK || $past(state_q) == ierf_pkg::S_DIV)
		else $error("result raised outside check or divide");

	// No result is shown while the statistics are still being worked out.
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ierf_pkg::S_MUL || state_q == ierf_pkg::S_DIV |-> !out_valid_q)
		else $error("result valid during statistics update");

	// A set minimum never exceeds the maximum.
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		min_q != '0 |-> min_q <= max_q)
		else $error("RTT minimum above maximum");
`endif

endmodule

/* tb/echo_reply_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_reply_checker: result predictor and comparator for the echo filter
// Watches the configuration port and both item channels of the ICMP echo
// reply filter. It keeps its own copy of the packet capture state and the
// RTT statistics, predicts one result per final byte and compares every
// result the block delivers with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module echo_reply_checker (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_we,
	input  logic [ierf_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [ierf_pkg::CfgDataW-1:0]  cfg_data,

	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	input  logic [23:0]                    rtt_time,

	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [2:0]                     status,
	input  logic [11:0]                    icmp_length,
	input  logic [7:0]                     ttl,
	input  logic [15:0]                    reply_sequence,
	input  logic [31:0]                    source_address,
	input  logic [23:0]                    reply_time,
	input  logic [23:0]                    rtt_minimum,
	input  logic [23:0]                    rtt_maximum,
	input  logic [23:0]                    rtt_average,
	input  logic [63:0]                    rtt_square_sum,
	input  logic [31:0]                    received_count,

	output int                             error_count,
	output int                             pending
);

	import ierf_pkg::*;

	// One predicted result item.
	typedef struct {
		status_t     status;
		logic [11:0] icmp_length;
		logic [7:0]  ttl;
		logic [15:0] reply_sequence;
		logic [31:0] source_address;
		logic [23:0] reply_time;
		logic [23:0] rtt_minimum;
		logic [23:0] rtt_maximum;
		logic [23:0] rtt_average;
		logic [63:0] rtt_square_sum;
		logic [31:0] received_count;
	} echo_result_t;

	echo_result_t expected_replies[$];

	// Register copies.
	logic [15:0] ident_reg;
	logic [15:0] next_seq;

	// Per-packet capture state.
	logic [11:0] pkt_pos;
	logic [3:0]  hdr_words;
	logic [7:0]  ttl_cap;
	logic [7:0]  proto_cap;
	logic [31:0] src_cap;
	logic [7:0]  type_cap;
	logic [7:0]  code_cap;
	logic [15:0] ident_cap;
	logic [15:0] seq_cap;

	// Running RTT statistics.
	logic [31:0] reply_total;
	logic [23:0] min_rtt;
	logic [23:0] max_rtt;
	logic [23:0] avg_rtt;
	logic [63:0] square_total;

	int errors;

	// Report and count one differing field.
	task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : model_step
		echo_result_t want;
		int pos;
		int hdr_bytes;
		int pkt_len;
		longint unsigned n;
		longint unsigned sq;

		if (!arst_n) begin
			ident_reg    = '0;
			next_seq     = '0;
			pkt_pos      = '0;
			hdr_words    = '0;
			ttl_cap      = '0;
			proto_cap    = '0;
			src_cap      = '0;
			type_cap     = '0;
			code_cap     = '0;
			ident_cap    = '0;
			seq_cap      = '0;
			reply_total  = '0;
			min_rtt      = '0;
			max_rtt      = '0;
			avg_rtt      = '0;
			square_total = '0;
			errors       = 0;
			expected_replies.delete();
			error_count <= 0;
			pending     <= 0;
		end else begin
			// A delivered result is matched against the oldest prediction.
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: result item with none expected, status %0h", $time, status);
					errors++;
				end else begin
					want = expected_replies.pop_front();
					check_field("status", want.status, status);
					check_field("icmp_length", want.icmp_length, icmp_length);
					check_field("ttl", want.ttl, ttl);
					check_field("reply_sequence", want.reply_sequence, reply_sequence);
					check_field("source_address", want.source_address, source_address);
					check_field("reply_time", want.reply_time, reply_time);
					check_field("rtt_minimum", want.rtt_minimum, rtt_minimum);
					check_field("rtt_maximum", want.rtt_maximum, rtt_maximum);
					check_field("rtt_average", want.rtt_average, rtt_average);
					check_field("rtt_square_sum", want.rtt_square_sum, rtt_square_sum);
					check_field("received_count", want.received_count, received_count);
				end
			end

			// Register writes; a start sequence write reloads the expected sequence.
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					CfgEchoIdentifier: ident_reg = cfg_data;
					CfgStartSequence:  next_seq = cfg_data;
					default: ;
				endcase
			end

			// An accepted byte is captured; bytes past the length limit are dropped.
			if (in_valid === 1'b1 && in_ready === 1'b1) begin
				if (pkt_pos < MaxPacketBytes) begin
					pos = pkt_pos;
					hdr_bytes = hdr_words * 4;
					if (pos == 0) hdr_words = data_byte[3:0];
					if (pos == 8) ttl_cap = data_byte;
					if (pos == 9) proto_cap = data_byte;
					if (pos >= 12 && pos <= 15) src_cap[(15 - pos) * 8 +: 8] = data_byte;
					if (pos != 0) begin
						if (pos == hdr_bytes)     type_cap = data_byte;
						if (pos == hdr_bytes + 1) code_cap = data_byte;
						if (pos == hdr_bytes + 4) ident_cap[15:8] = data_byte;
						if (pos == hdr_bytes + 5) ident_cap[7:0] = data_byte;
						if (pos == hdr_bytes + 6) seq_cap[15:8] = data_byte;
						if (pos == hdr_bytes + 7) seq_cap[7:0] = data_byte;
					end
					pkt_pos = pkt_pos + 12'd1;
				end

				// The final byte ends the packet and yields one result.
				if (last_byte === 1'b1) begin
					pkt_len = pkt_pos;
					hdr_bytes = hdr_words * 4;
					if (pkt_len < IpMinBytes)                        want.status = ST_TRUNCATED;
					else if (hdr_words < MinHeaderWords)             want.status = ST_HEADER_SHORT;
					else if (pkt_len < hdr_bytes)                    want.status = ST_TRUNCATED;
					else if (proto_cap != ProtoIcmp)                 want.status = ST_NOT_ICMP;
					else if (pkt_len < hdr_bytes + IcmpHdrBytes)     want.status = ST_TRUNCATED;
					else if (type_cap != TypeEchoReply)              want.status = ST_NOT_REPLY;
					else if (code_cap != 8'd0)                       want.status = ST_BAD_CODE;
					else if (ident_cap != ident_reg)                 want.status = ST_BAD_IDENT;
					else if (seq_cap != next_seq)                    want.status = ST_BAD_SEQUENCE;
					else                                             want.status = ST_ACCEPTED;

					want.icmp_length = '0;
					want.reply_time  = '0;
					if (want.status == ST_ACCEPTED) begin
						next_seq = next_seq + 16'd1;
						if (reply_total != 32'hFFFF_FFFF) reply_total = reply_total + 32'd1;
						if (rtt_time > max_rtt) max_rtt = rtt_time;
						// A zero minimum means unset and is replaced.
						if (min_rtt == 24'd0 || rtt_time < min_rtt) min_rtt = rtt_time;
						n = reply_total;
						avg_rtt = 24'((64'(avg_rtt) * (n - 1) + 64'(rtt_time)) / n);
						sq = 64'(rtt_time) * 64'(rtt_time);
						if (square_total > 64'hFFFF_FFFF_FFFF_FFFF - sq) square_total = '1;
						else square_total = square_total + sq;
						want.icmp_length = 12'(pkt_len - hdr_bytes);
						want.reply_time  = rtt_time;
					end
					want.ttl            = ttl_cap;
					want.reply_sequence = seq_cap;
					want.source_address = src_cap;
					want.rtt_minimum    = min_rtt;
					want.rtt_maximum    = max_rtt;
					want.rtt_average    = avg_rtt;
					want.rtt_square_sum = square_total;
					want.received_count = reply_total;
					expected_replies.push_back(want);

					pkt_pos   = '0;
					hdr_words = '0;
					ttl_cap   = '0;
					proto_cap = '0;
					src_cap   = '0;
					type_cap  = '0;
					code_cap  = '0;
					ident_cap = '0;
					seq_cap   = '0;
				end
			end

			error_count <= errors;
			pending     <= expected_replies.size();
		end
	end

endmodule

/* tb/tb_icmp_echo_reply_filter_rtt_stats_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_icmp_echo_reply_filter_rtt_stats_top: testbench for the echo filter
// Feeds IPv4 packets byte by byte into the filter: a directed set of edge
// packets first, then random phases of mostly well-formed echo replies mixed
// with broken and noise packets under new register settings. Both channels
// idle at random; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_icmp_echo_reply_filter_rtt_stats_top;

	import ierf_pkg::*;

	localparam int DrainCycles   = 120;
	localparam int HoldCycles    = 600;
	localparam int WatchdogLimit = 5000;
	localparam int ItemsTarget   = 1650;
	localparam int MinPackets    = 18;
	localparam int Phases        = 6;

	// Indexes that select no register.
	localparam logic [CfgIndexW-1:0] CfgUnusedLow  = 2'd2;
	localparam logic [CfgIndexW-1:0] CfgUnusedHigh = 2'd3;

	// Shapes of generated packets.
	typedef enum int {
		PK_GOOD,
		PK_TRUNC_ICMP,
		PK_SHORT_HDR,
		PK_BAD_PROTO,
		PK_BAD_KIND,
		PK_BAD_CODE,
		PK_BAD_IDENT,
		PK_BAD_SEQ,
		PK_NOISE,
		PK_TRUNC_IP
	} pkt_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte = '0;
	logic                 last_byte = 1'b0;
	logic [23:0]          rtt_time = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [2:0]           status;
	logic [11:0]          icmp_length;
	logic [7:0]           ttl;
	logic [15:0]          reply_sequence;
	logic [31:0]          source_address;
	logic [23:0]          reply_time;
	logic [23:0]          rtt_minimum;
	logic [23:0]          rtt_maximum;
	logic [23:0]          rtt_average;
	logic [63:0]          rtt_square_sum;
	logic [31:0]          received_count;

	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          items_sent = 0;
	int          packets_sent = 0;
	bit          hold_pending = 1'b0;
	logic [15:0] cur_ident;
	logic [15:0] next_seq;
	logic [7:0]  pkt_q[$];

	always #5 clk = ~clk;

	icmp_echo_reply_filter_rtt_stats_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.rtt_time       (rtt_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.icmp_length    (icmp_length),
		.ttl            (ttl),
		.reply_sequence (reply_sequence),
		.source_address (source_address),
		.reply_time     (reply_time),
		.rtt_minimum    (rtt_minimum),
		.rtt_maximum    (rtt_maximum),
		.rtt_average    (rtt_average),
		.rtt_square_sum (rtt_square_sum),
		.received_count (received_count)
	);

	echo_reply_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.rtt_time       (rtt_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.icmp_length    (icmp_length),
		.ttl            (ttl),
		.reply_sequence (reply_sequence),
		.source_address (source_address),
		.reply_time     (reply_time),
		.rtt_minimum    (rtt_minimum),
		.rtt_maximum    (rtt_maximum),
		.rtt_average    (rtt_average),
		.rtt_square_sum (rtt_square_sum),
		.received_count (received_count),
		.error_count    (fail_count),
		.pending        (pending)
	);

	// Watchdog: end the run when no item moves for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random stalls, calm stretches and one long hold-off.
	initial begin : receiver
		int stall;
		int calm;
		calm = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				stall = HoldCycles;
				hold_pending = 1'b0;
			end else if (calm > 0) begin
				stall = 0;
				calm--;
			end else begin
				stall = $urandom_range(0, 10);
				if ($urandom_range(0, 7) == 0) calm = 12;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
		end
	end

	// Write one register; the enable drops again before the next write.
	task automatic program_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering bytes and wait until every result has come and the block is quiet.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic start_phase(input logic [15:0] ident, input logic [15:0] first_seq);
		drain_block();
		program_reg(CfgEchoIdentifier, ident);
		program_reg(CfgStartSequence, first_seq);
		cur_ident = ident;
		next_seq  = first_seq;
	endtask

	// Build an IPv4 packet carrying an ICMP header and some payload.
	task automatic make_echo(input int hw, input int extra, input logic [7:0] proto,
			input logic [7:0] icmp_kind, input logic [7:0] echo_code,
			input logic [15:0] ident, input logic [15:0] seq);
		logic [3:0] version;
		version = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4;
		pkt_q.delete();
		pkt_q.push_back({version, 4'(hw)});
		for (int i = 1; i < 20; i++) pkt_q.push_back((i == 9) ? proto : 8'($urandom));
		repeat ((hw > 5) ? (hw - 5) * 4 : 0) pkt_q.push_back(8'($urandom));
		pkt_q.push_back(icmp_kind);
		pkt_q.push_back(echo_code);
		pkt_q.push_back(8'($urandom));
		pkt_q.push_back(8'($urandom));
		pkt_q.push_back(ident[15:8]);
		pkt_q.push_back(ident[7:0]);
		pkt_q.push_back(seq[15:8]);
		pkt_q.push_back(seq[7:0]);
		repeat (extra) pkt_q.push_back(8'($urandom));
	endtask

	task automatic make_good(input int hw, input int extra);
		make_echo(hw, extra, ProtoIcmp, TypeEchoReply, 8'd0, cur_ident, next_seq);
	endtask

	task automatic trim_packet(input int keep);
		while (pkt_q.size() > keep) void'(pkt_q.pop_back());
	endtask

	// Offer the built packet one item per byte; the RTT rides on the last byte.
	task automatic send_packet(input logic [23:0] rtt, input bit fast);
		int gap;
		for (int i = 0; i < pkt_q.size(); i++) begin
			gap = fast ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid  <= 1'b1;
			data_byte <= pkt_q[i];
			last_byte <= (i == pkt_q.size() - 1);
			rtt_time  <= (i == pkt_q.size() - 1) ? rtt : 24'($urandom);
			@(posedge clk);
			while (in_ready !== 1'b1) @(posedge clk);
		end
		items_sent += pkt_q.size();
		packets_sent++;
	endtask

	initial begin : stimulus
		pkt_kind_t kind;
		int hw;
		int extra;
		int items_goal;
		int packets_goal;
		logic [23:0] rtt;
		bit fast;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Writes to unused indexes must change nothing.
		program_reg(CfgUnusedLow, 16'($urandom));
		program_reg(CfgUnusedHigh, 16'($urandom));
		start_phase(16'hFFFF, 16'hFFFE);

		// Accepted zero RTT leaves the minimum unset.
		make_good(5, 0);
		next_seq++;
		send_packet(24'd0, 1'b0);
		// Largest RTT, and the expected sequence wraps past all ones.
		make_good(5, 16);
		next_seq++;
		send_packet(24'hFFFFFF, 1'b1);
		make_good(15, 3);
		next_seq++;
		send_packet(24'd1, 1'b0);
		// A single-byte packet: every later field reads as never received.
		make_good(5, 0);
		trim_packet(1);
		send_packet(24'($urandom), 1'b0);
		// Header length under five with exactly the minimum length.
		make_echo(0, 0, ProtoIcmp, TypeEchoReply, 8'd0, cur_ident, next_seq);
		trim_packet(20);
		send_packet(24'($urandom), 1'b0);
		make_echo(4, 4, ProtoIcmp, TypeEchoReply, 8'd0, cur_ident, next_seq);
		send_packet(24'($urandom), 1'b1);
		// Packet shorter than its own IP header.
		make_good(15, 0);
		trim_packet(40);
		send_packet(24'($urandom), 1'b0);
		make_echo(5, 2, 8'hFF, TypeEchoReply, 8'd0, cur_ident, next_seq);
		send_packet(24'($urandom), 1'b0);
		// One byte short of the ICMP header.
		make_good(5, 0);
		trim_packet(27);
		send_packet(24'($urandom), 1'b0);
		make_echo(5, 0, ProtoIcmp, 8'h08, 8'd0, cur_ident, next_seq);
		send_packet(24'($urandom), 1'b0);
		make_echo(5, 0, ProtoIcmp, TypeEchoReply, 8'hFF, cur_ident, next_seq);
		send_packet(24'($urandom), 1'b0);
		make_echo(5, 0, ProtoIcmp, TypeEchoReply, 8'd0, ~cur_ident, next_seq);
		send_packet(24'($urandom), 1'b0);
		make_echo(5, 0, ProtoIcmp, TypeEchoReply, 8'd0, cur_ident, next_seq ^ 16'h8000);
		send_packet(24'($urandom), 1'b0);
		// Oversized packet: the tail is dropped and the length saturates.
		make_good(5, 2060 - 28);
		next_seq++;
		send_packet(24'($urandom), 1'b1);
		make_echo(5, 0, 8'h00, TypeEchoReply, 8'd0, cur_ident, next_seq);
		send_packet(24'($urandom), 1'b0);

		// Random phases, each under its own register setting; together with the
		// directed packets they fill the overall item budget.
		for (int phase = 0; phase < Phases; phase++) begin
			case (phase)
				0: start_phase(16'h0000, 16'h0000);
				1: start_phase(16'hFFFF, 16'hFFFF);
				3: start_phase(16'($urandom), 16'hFFFA);
				default: start_phase(16'($urandom), 16'($urandom));
			endcase
			// Result side holds off while packets keep coming.
			if (phase == 2) hold_pending = 1'b1;
			items_goal   = ItemsTarget * (phase + 1) / Phases;
			packets_goal = packets_sent + MinPackets / Phases;
			while (items_sent < items_goal || packets_sent < packets_goal) begin
				kind = ($urandom_range(0, 99) < 55) ? PK_GOOD : pkt_kind_t'($urandom_range(1, 9));
				hw = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
				extra = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
				fast = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 7))
					0: rtt = '0;
					1: rtt = '1;
					2: rtt = 24'($urandom_range(1, 1000));
					default: rtt = 24'($urandom);
				endcase
				case (kind)
					PK_GOOD: begin
						make_good(hw, extra);
						next_seq++;
					end
					PK_TRUNC_ICMP: begin
						make_good(hw, extra);
						trim_packet($urandom_range(1, hw * 4 + IcmpHdrBytes - 1));
					end
					PK_TRUNC_IP: begin
						hw = $urandom_range(6, 15);
						make_good(hw, extra);
						trim_packet($urandom_range(1, hw * 4 - 1));
					end
					PK_SHORT_HDR: begin
						make_good($urandom_range(0, 4), extra);
					end
					PK_BAD_PROTO: begin
						make_echo(hw, extra, ProtoIcmp + 8'($urandom_range(1, 255)), TypeEchoReply,
							8'd0, cur_ident, next_seq);
					end
					PK_BAD_KIND: begin
						make_echo(hw, extra, ProtoIcmp, TypeEchoReply + 8'($urandom_range(1, 255)),
							8'd0, cur_ident, next_seq);
					end
					PK_BAD_CODE: begin
						make_echo(hw, extra, ProtoIcmp, TypeEchoReply, 8'($urandom_range(1, 255)),
							cur_ident, next_seq);
					end
					PK_BAD_IDENT: begin
						make_echo(hw, extra, ProtoIcmp, TypeEchoReply, 8'd0,
							cur_ident + 16'($urandom_range(1, 65535)), next_seq);
					end
					PK_BAD_SEQ: begin
						make_echo(hw, extra, ProtoIcmp, TypeEchoReply, 8'd0, cur_ident,
							next_seq + 16'($urandom_range(1, 65535)));
					end
					default: begin
						pkt_q.delete();
						repeat ($urandom_range(1, 60)) pkt_q.push_back(8'($urandom));
					end
				endcase
				send_packet(rtt, fast);
			end
		end

		drain_block();
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
